### rtl/core/alu_pkg.sv
package alu_pkg;

    localparam logic [4:0] MODE_ADD   = 5'd0;
    localparam logic [4:0] MODE_ADDC  = 5'd1;
    localparam logic [4:0] MODE_SUB   = 5'd2;
    localparam logic [4:0] MODE_SUBC  = 5'd3;
    localparam logic [4:0] MODE_DADD  = 5'd4;
    localparam logic [4:0] MODE_CMP   = 5'd5;
    localparam logic [4:0] MODE_XOR   = 5'd6;
    localparam logic [4:0] MODE_AND   = 5'd7;
    localparam logic [4:0] MODE_BIT   = 5'd8;
    localparam logic [4:0] MODE_BIC   = 5'd9;
    localparam logic [4:0] MODE_BIS   = 5'd10;
    localparam logic [4:0] MODE_MOV   = 5'd11;
    localparam logic [4:0] MODE_SRA   = 5'd12;
    localparam logic [4:0] MODE_RRC   = 5'd13;
    localparam logic [4:0] MODE_SWPB  = 5'd14;
    localparam logic [4:0] MODE_SXT   = 5'd15;
    localparam logic [4:0] MODE_MOVL  = 5'd16;
    localparam logic [4:0] MODE_MOVLZ = 5'd17;
    localparam logic [4:0] MODE_MOVLS = 5'd18;
    localparam logic [4:0] MODE_MOVH  = 5'd19;

    // Indexed by {operand msb, destination msb, sum msb}.
    localparam logic [7:0] CARRY_TAB = 8'b1101_0100;
    localparam logic [7:0] OVF_TAB   = 8'b0100_0010;

    localparam logic [4:0] DEC_BASE = 5'd10;

    typedef struct packed {
        logic [4:0]  mode;
        logic        byte_mode;
        logic [15:0] src_value;
        logic [15:0] dst_value;
        logic        carry_in;
        logic        zero_in;
        logic        negative_in;
        logic        overflow_in;
    } t_alu_req;

    typedef struct packed {
        logic [15:0] result;
        logic        write_back;
        logic        carry_out;
        logic        zero_out;
        logic        negative_out;
        logic        overflow_out;
    } t_alu_rsp;

endpackage

### rtl/core/cpu_alu_with_status_flags.sv
// Sixteen-bit ALU with C, Z, N and V status flags and a decimal add.
// The input channel (i_valid, o_ready) carries one item: the mode, the width,
// the source and destination values and the current flags. The output
// channel (o_valid, i_ready) returns one item per input item: the new
// destination value, the write-back flag and the updated flags.
// An accepted item is held in an input register; the operation is computed
// in one pass of combinational logic and lands in a result register, which
// drives the outputs, at a clock edge on which that register is free.
// One item can be accepted in every cycle while the receiver takes results,
// so the block then sustains one item per cycle.
// When the receiver stalls, the result register holds its item, the input
// register fills behind it, and o_ready drops only once both are occupied;
// no item is lost or repeated.
// The synchronous active-low reset empties both registers; the block keeps
// no other state.
module cpu_alu_with_status_flags
    import alu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [4:0]  i_mode,
    input  logic        i_byte_mode,
    input  logic [15:0] i_src_value,
    input  logic [15:0] i_dst_value,
    input  logic        i_carry_in,
    input  logic        i_zero_in,
    input  logic        i_negative_in,
    input  logic        i_overflow_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_result,
    output logic        o_write_back,
    output logic        o_carry_out,
    output logic        o_zero_out,
    output logic        o_negative_out,
    output logic        o_overflow_out
);

    t_alu_req r_in;
    logic     r_in_valid;
    t_alu_rsp r_out;
    logic     r_out_valid;
    t_alu_rsp n_out;
    logic     out_free;
    logic     in_free;

    assign out_free = !r_out_valid || i_ready;
    assign in_free  = !r_in_valid || out_free;
    assign o_ready  = in_free;

    always_comb begin
        logic [15:0] mask;
        logic [15:0] top;
        logic [15:0] hi;
        logic [15:0] d;
        logic [15:0] s;
        logic [15:0] op;
        logic [15:0] r;
        logic [15:0] w;
        logic [15:0] acc;
        logic [4:0]  t;
        logic [4:0]  cy;
        logic [2:0]  idx;
        logic        ci;
        logic        is_sub;

        mask   = r_in.byte_mode ? 16'h00FF : 16'hFFFF;
        top    = r_in.byte_mode ? 16'h0080 : 16'h8000;
        hi     = r_in.dst_value & ~mask;
        d      = r_in.dst_value & mask;
        s      = r_in.src_value & mask;
        is_sub = (r_in.mode == MODE_SUB) || (r_in.mode == MODE_SUBC)
              || (r_in.mode == MODE_CMP);
        op     = is_sub ? (~r_in.src_value & mask) : s;
        if (r_in.mode == MODE_ADD) begin
            ci = 1'b0;
        end else if (r_in.mode == MODE_ADDC || r_in.mode == MODE_SUBC) begin
            ci = r_in.carry_in;
        end else begin
            ci = 1'b1;
        end
        r   = (d + op + {15'd0, ci}) & mask;
        idx = {|(op & top), |(d & top), |(r & top)};

        cy[0] = r_in.carry_in;
        acc   = 16'd0;
        for (int i = 0; i < 4; i++) begin
            t = {1'b0, r_in.src_value[4*i +: 4]} + {1'b0, r_in.dst_value[4*i +: 4]}
              + {4'd0, cy[i]};
            if (t >= DEC_BASE) begin
                t = t - DEC_BASE;
                cy[i+1] = 1'b1;
            end else begin
                cy[i+1] = 1'b0;
            end
            acc[4*i +: 4] = t[3:0];
        end

        w = 16'd0;
        n_out.result       = r_in.dst_value;
        n_out.write_back   = 1'b1;
        n_out.carry_out    = r_in.carry_in;
        n_out.zero_out     = r_in.zero_in;
        n_out.negative_out = r_in.negative_in;
        n_out.overflow_out = r_in.overflow_in;

        unique case (r_in.mode)
            MODE_ADD, MODE_ADDC, MODE_SUB, MODE_SUBC, MODE_CMP: begin
                n_out.carry_out    = CARRY_TAB[idx];
                n_out.overflow_out = OVF_TAB[idx];
                w = r;
                if (r_in.mode == MODE_CMP) begin
                    n_out.write_back = 1'b0;
                end else begin
                    n_out.result = hi | r;
                end
            end
            MODE_DADD: begin
                n_out.result    = r_in.byte_mode ? {r_in.dst_value[15:8], acc[7:0]} : acc;
                n_out.carry_out = r_in.byte_mode ? cy[2] : cy[4];
            end
            MODE_XOR: begin
                w = d ^ s;
                n_out.result = hi | w;
            end
            MODE_AND: begin
                w = d & s;
                n_out.result = hi | w;
            end
            MODE_BIT: begin
                w = d & s;
                n_out.write_back = 1'b0;
            end
            MODE_BIC: begin
                w = d & ~s & mask;
                n_out.result = hi | w;
            end
            MODE_BIS: begin
                w = d | s;
                n_out.result = hi | w;
            end
            MODE_MOV: begin
                n_out.result = hi | s;
            end
            MODE_SRA, MODE_RRC: begin
                if (r_in.mode == MODE_SRA) begin
                    w = (d >> 1) | (d & top);
                end else begin
                    w = (d >> 1) | (r_in.carry_in ? top : 16'd0);
                end
                n_out.carry_out = d[0];
                n_out.result    = hi | w;
            end
            MODE_SWPB: begin
                w = {r_in.dst_value[7:0], r_in.dst_value[15:8]};
                n_out.result = w;
            end
            MODE_SXT: begin
                w = {{8{r_in.dst_value[7]}}, r_in.dst_value[7:0]};
                n_out.result = w;
            end
            MODE_MOVL: begin
                n_out.result = {r_in.dst_value[15:8], r_in.src_value[7:0]};
            end
            MODE_MOVLZ: begin
                n_out.result = {8'h00, r_in.src_value[7:0]};
            end
            MODE_MOVLS: begin
                n_out.result = {8'hFF, r_in.src_value[7:0]};
            end
            MODE_MOVH: begin
                n_out.result = {r_in.src_value[7:0], r_in.dst_value[7:0]};
            end
            default: begin
                n_out.write_back = 1'b0;
            end
        endcase

        if ((r_in.mode == MODE_ADD) || (r_in.mode == MODE_ADDC) || (r_in.mode == MODE_SUB)
                || (r_in.mode == MODE_SUBC) || (r_in.mode == MODE_CMP)
                || (r_in.mode == MODE_XOR) || (r_in.mode == MODE_AND)
                || (r_in.mode == MODE_BIT) || (r_in.mode == MODE_BIC)
                || (r_in.mode == MODE_BIS) || (r_in.mode == MODE_SRA)
                || (r_in.mode == MODE_RRC) || (r_in.mode == MODE_SWPB)
                || (r_in.mode == MODE_SXT)) begin
            n_out.negative_out = |(w & top);
            n_out.zero_out     = ((w & mask) == 16'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_free) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
        if (in_free && i_valid) begin
            r_in.mode        <= i_mode;
            r_in.byte_mode   <= i_byte_mode;
            r_in.src_value   <= i_src_value;
            r_in.dst_value   <= i_dst_value;
            r_in.carry_in    <= i_carry_in;
            r_in.zero_in     <= i_zero_in;
            r_in.negative_in <= i_negative_in;
            r_in.overflow_in <= i_overflow_in;
        end
        if (out_free && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result       = r_out.result;
    assign o_write_back   = r_out.write_back;
    assign o_carry_out    = r_out.carry_out;
    assign o_zero_out     = r_out.zero_out;
    assign o_negative_out = r_out.negative_out;
    assign o_overflow_out = r_out.overflow_out;

endmodule

### dv/tb_cpu_alu_with_status_flags.sv
`timescale 1ns / 1ps

module tb_cpu_alu_with_status_flags
    import alu_pkg::*;
();

    localparam logic [4:0] MODE_SPARE_FIRST = MODE_MOVH + 5'd1;
    localparam logic [4:0] MODE_SPARE_LAST  = 5'd31;
    localparam logic [4:0] DEC_RADIX        = 5'd10;
    localparam int         ITEMS_PER_PHASE  = 200;
    localparam int         WATCHDOG_CYCLES  = 2000;
    localparam int         TAIL_CYCLES      = 10;
    localparam int         MAX_PRINTED      = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [4:0]  i_mode = '0;
    logic        i_byte_mode = 1'b0;
    logic [15:0] i_src_value = '0;
    logic [15:0] i_dst_value = '0;
    logic        i_carry_in = 1'b0;
    logic        i_zero_in = 1'b0;
    logic        i_negative_in = 1'b0;
    logic        i_overflow_in = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_result;
    logic        o_write_back;
    logic        o_carry_out;
    logic        o_zero_out;
    logic        o_negative_out;
    logic        o_overflow_out;

    t_alu_req op_q[$];
    t_alu_rsp alu_expect_q[$];
    t_alu_req drv_op;
    t_alu_rsp got_rsp;
    t_alu_rsp want_rsp;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int ops_sent = 0;
    int ops_taken = 0;
    int results_seen = 0;
    int byte_ops = 0;
    int spare_ops = 0;
    int err_count = 0;
    int quiet_cycles = 0;

    cpu_alu_with_status_flags u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_byte_mode    (i_byte_mode),
        .i_src_value    (i_src_value),
        .i_dst_value    (i_dst_value),
        .i_carry_in     (i_carry_in),
        .i_zero_in      (i_zero_in),
        .i_negative_in  (i_negative_in),
        .i_overflow_in  (i_overflow_in),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result       (o_result),
        .o_write_back   (o_write_back),
        .o_carry_out    (o_carry_out),
        .o_zero_out     (o_zero_out),
        .o_negative_out (o_negative_out),
        .o_overflow_out (o_overflow_out)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [1:0] neg_zero(logic [15:0] r, logic byte_w);
        return byte_w ? {r[7], r[7:0] == 8'h00} : {r[15], r == 16'h0000};
    endfunction

    function automatic t_alu_rsp alu_predict(t_alu_req rq);
        logic [15:0] mask, top, hi, d, s, op, r, acc, res;
        logic [16:0] sum;
        logic [4:0]  dig;
        logic        c, z, n, v, wb, cy, is_sub;
        t_alu_rsp    rs;
        mask = rq.byte_mode ? 16'h00FF : 16'hFFFF;
        top  = rq.byte_mode ? 16'h0080 : 16'h8000;
        hi   = rq.dst_value & ~mask;
        d    = rq.dst_value & mask;
        s    = rq.src_value & mask;
        res  = rq.dst_value;
        wb   = 1'b1;
        c    = rq.carry_in;
        z    = rq.zero_in;
        n    = rq.negative_in;
        v    = rq.overflow_in;
        case (rq.mode)
            MODE_ADD, MODE_ADDC, MODE_SUB, MODE_SUBC, MODE_CMP: begin
                is_sub = (rq.mode == MODE_SUB) || (rq.mode == MODE_SUBC) ||
                         (rq.mode == MODE_CMP);
                op = is_sub ? (~rq.src_value & mask) : s;
                if (rq.mode == MODE_ADD) begin
                    cy = 1'b0;
                end else if (rq.mode == MODE_ADDC || rq.mode == MODE_SUBC) begin
                    cy = rq.carry_in;
                end else begin
                    cy = 1'b1;
                end
                sum = {1'b0, d} + {1'b0, op} + {16'h0000, cy};
                r = sum[15:0] & mask;
                c = rq.byte_mode ? sum[8] : sum[16];
                v = (((op ^ d) & top) == 16'h0000) && (((r ^ op) & top) != 16'h0000);
                {n, z} = neg_zero(r, rq.byte_mode);
                if (rq.mode == MODE_CMP) begin
                    wb = 1'b0;
                end else begin
                    res = hi | r;
                end
            end
            MODE_DADD: begin
                cy  = rq.carry_in;
                acc = '0;
                for (int i = 0; i < (rq.byte_mode ? 2 : 4); i++) begin
                    dig = {1'b0, rq.src_value[4*i +: 4]} + {1'b0, rq.dst_value[4*i +: 4]}
                        + {4'h0, cy};
                    if (dig >= DEC_RADIX) begin
                        dig = dig - DEC_RADIX;
                        cy  = 1'b1;
                    end else begin
                        cy = 1'b0;
                    end
                    acc[4*i +: 4] = dig[3:0];
                end
                res = hi | acc;
                c   = cy;
            end
            MODE_XOR: begin
                r = d ^ s;
                {n, z} = neg_zero(r, rq.byte_mode);
                res = hi | r;
            end
            MODE_AND, MODE_BIT: begin
                r = d & s;
                {n, z} = neg_zero(r, rq.byte_mode);
                if (rq.mode == MODE_BIT) begin
                    wb = 1'b0;
                end else begin
                    res = hi | r;
                end
            end
            MODE_BIC: begin
                r = d & ~s & mask;
                {n, z} = neg_zero(r, rq.byte_mode);
                res = hi | r;
            end
            MODE_BIS: begin
                r = d | s;
                {n, z} = neg_zero(r, rq.byte_mode);
                res = hi | r;
            end
            MODE_MOV: begin
                res = hi | s;
            end
            MODE_SRA, MODE_RRC: begin
                if (rq.mode == MODE_SRA) begin
                    r = (d >> 1) | (d & top);
                end else begin
                    r = (d >> 1) | (rq.carry_in ? top : 16'h0000);
                end
                c = d[0];
                {n, z} = neg_zero(r, rq.byte_mode);
                res = hi | r;
            end
            MODE_SWPB: begin
                res = {rq.dst_value[7:0], rq.dst_value[15:8]};
                {n, z} = neg_zero(res, rq.byte_mode);
            end
            MODE_SXT: begin
                res = {{8{rq.dst_value[7]}}, rq.dst_value[7:0]};
                {n, z} = neg_zero(res, rq.byte_mode);
            end
            MODE_MOVL:  res = {rq.dst_value[15:8], rq.src_value[7:0]};
            MODE_MOVLZ: res = {8'h00, rq.src_value[7:0]};
            MODE_MOVLS: res = {8'hFF, rq.src_value[7:0]};
            MODE_MOVH:  res = {rq.src_value[7:0], rq.dst_value[7:0]};
            default:    wb = 1'b0;
        endcase
        rs.result       = res;
        rs.write_back   = wb;
        rs.carry_out    = c;
        rs.zero_out     = z;
        rs.negative_out = n;
        rs.overflow_out = v;
        return rs;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        err_count++;
        if (err_count <= MAX_PRINTED) begin
            $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
    endtask

    task automatic queue_op(logic [4:0] mode, logic byte_w, logic [15:0] src,
                            logic [15:0] dst, logic [3:0] cznv);
        t_alu_req rq;
        rq.mode        = mode;
        rq.byte_mode   = byte_w;
        rq.src_value   = src;
        rq.dst_value   = dst;
        rq.carry_in    = cznv[3];
        rq.zero_in     = cznv[2];
        rq.negative_in = cznv[1];
        rq.overflow_in = cznv[0];
        op_q.push_back(rq);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(15))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            4:       return 16'h0080;
            5:       return 16'h007F;
            6:       return 16'h00FF;
            7:       return 16'hFF00;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_bcd();
        logic [15:0] w;
        for (int i = 0; i < 4; i++) begin
            w[4*i +: 4] = 4'($urandom_range(9));
        end
        return w;
    endfunction

    task automatic queue_random_ops(int count);
        logic [4:0]  mode;
        logic [15:0] src, dst;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(24) == 0) begin
                mode = 5'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
            end else begin
                mode = 5'($urandom_range(MODE_MOVH));
            end
            if (mode == MODE_DADD && $urandom_range(3) != 0) begin
                src = pick_bcd();
                dst = pick_bcd();
            end else begin
                src = pick_word();
                dst = ($urandom_range(7) == 0) ? src : pick_word();
            end
            queue_op(mode, 1'($urandom_range(1)), src, dst, 4'($urandom_range(15)));
        end
    endtask

    task automatic wait_drained();
        while (op_q.size() != 0 || ops_sent != ops_taken || alu_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
            if (ops_sent == ops_taken) begin
                if (op_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    drv_op = op_q.pop_front();
                    i_mode        <= drv_op.mode;
                    i_byte_mode   <= drv_op.byte_mode;
                    i_src_value   <= drv_op.src_value;
                    i_dst_value   <= drv_op.dst_value;
                    i_carry_in    <= drv_op.carry_in;
                    i_zero_in     <= drv_op.zero_in;
                    i_negative_in <= drv_op.negative_in;
                    i_overflow_in <= drv_op.overflow_in;
                    i_valid       <= 1'b1;
                    ops_sent++;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                alu_expect_q.push_back(alu_predict('{i_mode, i_byte_mode, i_src_value,
                    i_dst_value, i_carry_in, i_zero_in, i_negative_in, i_overflow_in}));
                ops_taken <= ops_taken + 1;
                if (i_byte_mode) byte_ops <= byte_ops + 1;
                if (i_mode > MODE_MOVH) spare_ops <= spare_ops + 1;
            end
            if (o_valid && i_ready) begin
                got_rsp = '{o_result, o_write_back, o_carry_out, o_zero_out,
                            o_negative_out, o_overflow_out};
                results_seen <= results_seen + 1;
                if (alu_expect_q.size() == 0) begin
                    report_mismatch("result with nothing pending", got_rsp.result, 16'h0000);
                end else begin
                    want_rsp = alu_expect_q.pop_front();
                    if (got_rsp.result !== want_rsp.result)
                        report_mismatch("result", got_rsp.result, want_rsp.result);
                    if (got_rsp.write_back !== want_rsp.write_back)
                        report_mismatch("write_back", 16'(got_rsp.write_back),
                                        16'(want_rsp.write_back));
                    if (got_rsp.carry_out !== want_rsp.carry_out)
                        report_mismatch("carry_out", 16'(got_rsp.carry_out),
                                        16'(want_rsp.carry_out));
                    if (got_rsp.zero_out !== want_rsp.zero_out)
                        report_mismatch("zero_out", 16'(got_rsp.zero_out),
                                        16'(want_rsp.zero_out));
                    if (got_rsp.negative_out !== want_rsp.negative_out)
                        report_mismatch("negative_out", 16'(got_rsp.negative_out),
                                        16'(want_rsp.negative_out));
                    if (got_rsp.overflow_out !== want_rsp.overflow_out)
                        report_mismatch("overflow_out", 16'(got_rsp.overflow_out),
                                        16'(want_rsp.overflow_out));
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_CYCLES) begin
                $display("Watchdog expired with %0d results outstanding.",
                         alu_expect_q.size());
                $display("tb_cpu_alu_with_status_flags: FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 17;
        rx_idle_pct = 45;
        queue_op(MODE_ADD,   1'b0, 16'hFFFF, 16'h0001, 4'b0000);
        queue_op(MODE_ADD,   1'b0, 16'h7FFF, 16'h0001, 4'b1111);
        queue_op(MODE_ADDC,  1'b1, 16'h00FF, 16'hAB00, 4'b1000);
        queue_op(MODE_SUB,   1'b0, 16'h0001, 16'h8000, 4'b0000);
        queue_op(MODE_SUBC,  1'b1, 16'h0001, 16'h1200, 4'b0000);
        queue_op(MODE_CMP,   1'b0, 16'h1234, 16'h1234, 4'b0001);
        queue_op(MODE_CMP,   1'b1, 16'h0080, 16'hFF7F, 4'b0100);
        queue_op(MODE_DADD,  1'b0, 16'h9999, 16'h0001, 4'b0000);
        queue_op(MODE_DADD,  1'b1, 16'h0099, 16'h5501, 4'b1000);
        queue_op(MODE_DADD,  1'b0, 16'hFFFF, 16'hFFFF, 4'b1111);
        queue_op(MODE_XOR,   1'b0, 16'hFFFF, 16'hFFFF, 4'b1001);
        queue_op(MODE_AND,   1'b1, 16'h0080, 16'hFFFF, 4'b0110);
        queue_op(MODE_BIT,   1'b0, 16'h8000, 16'h8001, 4'b0000);
        queue_op(MODE_BIC,   1'b1, 16'h00FF, 16'h12FF, 4'b1011);
        queue_op(MODE_BIS,   1'b0, 16'h8000, 16'h0000, 4'b0100);
        queue_op(MODE_MOV,   1'b1, 16'hFFAA, 16'h5500, 4'b1111);
        queue_op(MODE_SRA,   1'b0, 16'h0000, 16'h8001, 4'b0000);
        queue_op(MODE_SRA,   1'b1, 16'h0000, 16'h7F81, 4'b0001);
        queue_op(MODE_RRC,   1'b0, 16'h0000, 16'h0001, 4'b1000);
        queue_op(MODE_RRC,   1'b1, 16'h0000, 16'hFF00, 4'b0000);
        queue_op(MODE_SWPB,  1'b1, 16'h0000, 16'h80FF, 4'b0101);
        queue_op(MODE_SXT,   1'b0, 16'h0000, 16'h0080, 4'b0000);
        queue_op(MODE_SXT,   1'b1, 16'h0000, 16'hFF7F, 4'b1110);
        queue_op(MODE_MOVL,  1'b1, 16'hFF5A, 16'hA5A5, 4'b1111);
        queue_op(MODE_MOVLZ, 1'b0, 16'hFF80, 16'hFFFF, 4'b0000);
        queue_op(MODE_MOVLS, 1'b0, 16'h0001, 16'h0000, 4'b1010);
        queue_op(MODE_MOVH,  1'b1, 16'h00C3, 16'h1234, 4'b0101);
        queue_op(MODE_SPARE_LAST, 1'b1, 16'hFFFF, 16'h0000, 4'b1010);
        queue_random_ops(ITEMS_PER_PHASE);
        wait_drained();

        tx_idle_pct = 45;
        rx_idle_pct = 17;
        queue_random_ops(ITEMS_PER_PHASE);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_random_ops(ITEMS_PER_PHASE);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d results from %0d items: %0d byte width, %0d unused modes.",
                 results_seen, ops_taken, byte_ops, spare_ops);
        $display("Handshake profiles: sender and receiver stalls in both ratios, then none.");
        if (err_count == 0) begin
            $display("tb_cpu_alu_with_status_flags: PASS");
        end else begin
            $display("%0d mismatches in total.", err_count);
            $display("tb_cpu_alu_with_status_flags: FAIL");
        end
        $finish;
    end

endmodule
